>>> sv/icmp_echo_pkg.sv
// icmp_echo_pkg: shared types, codes and the ones-complement fold for the icmp echo responder
// no dependencies

package icmp_echo_pkg;

   // request opcodes
   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_PULL = 1'b1
   } opcode_type;

   // response kinds
   typedef enum logic {
      KIND_VERDICT = 1'b0,
      KIND_PULL    = 1'b1
   } kind_type;

   localparam int          LEN_W             = 12;
   localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
   localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'd0;
   localparam int          MIN_MESSAGE_BYTES = 8;

   // header byte positions that get special treatment
   localparam int          POS_TYPE   = 0;
   localparam int          POS_CKS_HI = 2;
   localparam int          POS_CKS_LO = 3;

   // two end-around-carry folds of a 17-bit sum down to 16 bits
   function automatic logic [15:0] fold16(input logic [16:0] s);
      logic [16:0] t;
      logic [15:0] r;
      t = {1'b0, s[15:0]} + {16'b0, s[16]};
      r = t[15:0] + {15'b0, t[16]};
      return r;
   endfunction

endpackage

>>> sv/icmp_echo_responder_top.sv
// icmp_echo_responder_top: icmp echo responder with rfc 1071 checksum and reply buffer
// depends on icmp_echo_pkg

// A push beat carries one byte of a received ICMP message in network order; the
// beat with in_last set also carries the sender address. Bytes go into a single
// message buffer of MAX_MESSAGE_BYTES entries (one synchronous memory, one write
// and one registered read port) while a 16-bit ones-complement sum is kept with
// the type and checksum bytes taken as zero. On the last byte one verdict beat is
// returned: an echo request of at least 8 bytes that fit the buffer becomes a
// queued echo reply (type 0, new checksum), anything else is dropped. Pull beats
// then read the reply out, one byte per beat; a pull with nothing pending gets a
// beat with ok_flag low. A push discards any reply still pending. The last push
// is followed by a checksum finish and verdict pass (S_FINAL); a pull first reads
// the message buffer through its registered read port, then builds the beat in
// S_READ. A non-final push is taken even while a response beat waits at the
// output; a beat that produces a response waits until the output register is
// free or being drained.

module icmp_echo_responder_top
   import icmp_echo_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = 2048
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [7:0]        req_in_byte,
   input  logic              req_in_last,
   input  logic [31:0]       req_peer_addr,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_result_kind,
   output logic              rsp_ok_flag,
   output logic [LEN_W-1:0]  rsp_reply_length,
   output logic [7:0]        rsp_reply_byte,
   output logic              rsp_reply_end,
   output logic [31:0]       rsp_reply_dest
);

   // address width of the buffer, count width able to hold the full size
   localparam int AW = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
   localparam int CW = $clog2(MAX_MESSAGE_BYTES + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_FINAL
   } state_type;

   // which source a pulled byte comes from
   typedef enum logic [1:0] {
      SEL_TYPE,
      SEL_CKS_HI,
      SEL_CKS_LO,
      SEL_MEM
   } sel_type;

   // control and loading state
   state_type       state_ff, state_in;
   logic [CW-1:0]   byte_count_ff, byte_count_in;
   logic            overflow_ff, overflow_in;
   logic [15:0]     sum_ff, sum_in;
   logic [7:0]      hold_ff, hold_in;
   logic [7:0]      type_ff, type_in;
   // queued reply state
   logic [15:0]     cks_ff, cks_in;
   logic            pending_ff, pending_in;
   logic [CW-1:0]   rp_ff, rp_in;
   logic [CW-1:0]   size_ff, size_in;
   logic [31:0]     dest_ff, dest_in;
   // per-beat payload carried into the S_READ and S_FINAL states
   logic [31:0]     peer_ff, peer_in;
   logic            pull_ok_ff, pull_ok_in;
   logic            pull_end_ff, pull_end_in;
   sel_type         pull_sel_ff, pull_sel_in;
   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_kind_ff, rsp_kind_in;
   logic            rsp_ok_ff, rsp_ok_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_end_ff, rsp_end_in;
   logic [31:0]     rsp_dest_ff, rsp_dest_in;

   // message buffer
   logic [7:0]      mem [MAX_MESSAGE_BYTES];
   logic [7:0]      rd_data_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic            mem_re;
   logic [AW-1:0]   mem_raddr;

   logic            accept;
   logic            in_range;
   logic [7:0]      lo_byte;
   logic [15:0]     sum_next;
   logic [16:0]     final_sum;
   logic            verdict_ok;
   logic            pull_ok;
   logic [CW-1:0]   rp_plus;
   logic            pull_end;
   logic [7:0]      pulled_byte;

   // a beat with no response may pass a waiting output beat
   assign req_ready = (state_ff == S_IDLE) &&
                      (!rsp_valid_ff || rsp_ready ||
                       (req_opcode == OP_PUSH && !req_in_last));
   assign accept    = req_valid && req_ready;

   // running sum of big-endian words, type and checksum bytes zeroed
   assign in_range  = byte_count_ff < CW'(MAX_MESSAGE_BYTES);
   assign lo_byte   = (byte_count_ff == CW'(POS_CKS_LO)) ? 8'h00 : req_in_byte;
   assign sum_next  = fold16({1'b0, sum_ff} + {1'b0, hold_ff, lo_byte});

   // odd length: pending high byte padded with zero on the right
   assign final_sum  = {1'b0, sum_ff} + (byte_count_ff[0] ? {1'b0, hold_ff, 8'h00} : 17'd0);
   assign verdict_ok = !overflow_ff && (byte_count_ff >= CW'(MIN_MESSAGE_BYTES)) &&
                       (type_ff == ICMP_ECHO_REQUEST);

   // pull bookkeeping
   assign pull_ok  = pending_ff && (rp_ff < size_ff);
   assign rp_plus  = rp_ff + CW'(1);
   assign pull_end = (rp_plus == size_ff);

   always_comb begin
      case (pull_sel_ff)
         SEL_TYPE:   pulled_byte = ICMP_ECHO_REPLY;
         SEL_CKS_HI: pulled_byte = cks_ff[15:8];
         SEL_CKS_LO: pulled_byte = cks_ff[7:0];
         SEL_MEM:    pulled_byte = rd_data_ff;
         default:    pulled_byte = rd_data_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      byte_count_in = byte_count_ff;
      overflow_in   = overflow_ff;
      sum_in        = sum_ff;
      hold_in       = hold_ff;
      type_in       = type_ff;
      cks_in        = cks_ff;
      pending_in    = pending_ff;
      rp_in         = rp_ff;
      size_in       = size_ff;
      dest_in       = dest_ff;
      peer_in       = peer_ff;
      pull_ok_in    = pull_ok_ff;
      pull_end_in   = pull_end_ff;
      pull_sel_in   = pull_sel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_dest_in   = rsp_dest_ff;
      mem_we        = 1'b0;
      mem_waddr     = byte_count_ff[AW-1:0];
      mem_re        = 1'b0;
      mem_raddr     = rp_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept && req_opcode == OP_PULL) begin
               // read the buffer now, build the beat next cycle
               mem_re      = 1'b1;
               pull_ok_in  = pull_ok;
               pull_end_in = pull_ok && pull_end;
               if (rp_ff == CW'(POS_TYPE)) begin
                  pull_sel_in = SEL_TYPE;
               end else if (rp_ff == CW'(POS_CKS_HI)) begin
                  pull_sel_in = SEL_CKS_HI;
               end else if (rp_ff == CW'(POS_CKS_LO)) begin
                  pull_sel_in = SEL_CKS_LO;
               end else begin
                  pull_sel_in = SEL_MEM;
               end
               if (pull_ok) begin
                  rp_in = rp_plus;
                  if (pull_end) begin
                     pending_in = 1'b0;
                  end
               end else begin
                  pending_in = 1'b0;
               end
               state_in = S_READ;
            end else if (accept) begin
               // a push drops any pending reply, the buffer is reused
               pending_in = 1'b0;
               if (in_range) begin
                  mem_we        = 1'b1;
                  byte_count_in = byte_count_ff + CW'(1);
                  if (byte_count_ff == CW'(POS_TYPE)) begin
                     type_in = req_in_byte;
                  end
                  if (!byte_count_ff[0]) begin
                     if (byte_count_ff == CW'(POS_TYPE) ||
                         byte_count_ff == CW'(POS_CKS_HI)) begin
                        hold_in = 8'h00;
                     end else begin
                        hold_in = req_in_byte;
                     end
                  end else begin
                     sum_in = sum_next;
                  end
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_in_last) begin
                  peer_in  = req_peer_addr;
                  state_in = S_FINAL;
               end
            end
         end

         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_PULL;
            rsp_ok_in    = pull_ok_ff;
            rsp_len_in   = pull_ok_ff ? LEN_W'(size_ff) : '0;
            rsp_byte_in  = pull_ok_ff ? pulled_byte : 8'h00;
            rsp_end_in   = pull_end_ff;
            rsp_dest_in  = pull_ok_ff ? dest_ff : 32'd0;
            state_in     = S_IDLE;
         end

         S_FINAL: begin
            // finish the checksum and give the verdict
            if (verdict_ok) begin
               cks_in     = ~fold16(final_sum);
               size_in    = byte_count_ff;
               rp_in      = '0;
               dest_in    = peer_ff;
               pending_in = 1'b1;
            end
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_VERDICT;
            rsp_ok_in     = verdict_ok;
            rsp_len_in    = verdict_ok ? LEN_W'(byte_count_ff) : '0;
            rsp_byte_in   = 8'h00;
            rsp_end_in    = 1'b0;
            rsp_dest_in   = verdict_ok ? peer_ff : 32'd0;
            byte_count_in = '0;
            overflow_in   = 1'b0;
            sum_in        = '0;
            hold_in       = '0;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      peer_ff     <= peer_in;
      pull_ok_ff  <= pull_ok_in;
      pull_end_ff <= pull_end_in;
      pull_sel_ff <= pull_sel_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_dest_ff <= rsp_dest_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         byte_count_ff <= '0;
         overflow_ff   <= 1'b0;
         sum_ff        <= '0;
         hold_ff       <= '0;
         type_ff       <= '0;
         cks_ff        <= '0;
         pending_ff    <= 1'b0;
         rp_ff         <= '0;
         size_ff       <= '0;
         dest_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         byte_count_ff <= byte_count_in;
         overflow_ff   <= overflow_in;
         sum_ff        <= sum_in;
         hold_ff       <= hold_in;
         type_ff       <= type_in;
         cks_ff        <= cks_in;
         pending_ff    <= pending_in;
         rp_ff         <= rp_in;
         size_ff       <= size_in;
         dest_ff       <= dest_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // message buffer, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_in_byte;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_ok_flag      = rsp_ok_ff;
   assign rsp_reply_length = rsp_len_ff;
   assign rsp_reply_byte   = rsp_byte_ff;
   assign rsp_reply_end    = rsp_end_ff;
   assign rsp_reply_dest   = rsp_dest_ff;

endmodule
